FILE: sv/admm_pkg.sv
// ----------------------------------------------------------------------------
// admm_pkg: shared types and constants of the armed differential drive mixer
// Codes for commands, motor targets and directions, field widths, and the
// constants used by the throttle/steer mixer.
// ----------------------------------------------------------------------------
package admm_pkg;

   localparam int OP_W    = 3;
   localparam int AXIS_W  = 11;
   localparam int DB_W    = 10;
   localparam int TGT_W   = 2;
   localparam int DIR_W   = 2;
   localparam int SPEED_W = 7;
   localparam int MIX_W   = AXIS_W + 1;
   localparam int MAG_W   = 10;
   localparam int RUN_MAX = 4;
   localparam int RUN_W   = 2;

   localparam logic [DB_W-1:0]         DEADBAND_RESET = 10'd20;
   localparam logic signed [MIX_W-1:0] MIX_LIMIT      = 12'sd1000;
   // speed = mag / 10, done as (mag * 205) >> 11, exact for mag up to 1000
   localparam logic [7:0]              RECIP          = 8'd205;
   localparam int                      RECIP_SHIFT    = 11;

   typedef enum logic [OP_W-1:0] {
      OP_MANUAL = 3'd0,
      OP_APPLY  = 3'd1,
      OP_ARM    = 3'd2,
      OP_DISARM = 3'd3,
      OP_SOFT   = 3'd4,
      OP_RESET  = 3'd5
   } op_type;

   typedef enum logic [TGT_W-1:0] {
      TGT_STOP  = 2'd0,
      TGT_LEFT  = 2'd1,
      TGT_RIGHT = 2'd2,
      TGT_HARD  = 2'd3
   } target_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_HALT = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef struct packed {
      dir_type             overall;
      logic                left_rev;
      logic                right_rev;
      logic [SPEED_W-1:0]  left_speed;
      logic [SPEED_W-1:0]  right_speed;
   } mix_result_type;

   typedef struct packed {
      target_type          target;
      dir_type             dir;
      logic [SPEED_W-1:0]  speed;
   } entry_type;

endpackage

FILE: sv/admm_if.sv
// ----------------------------------------------------------------------------
// admm_if: valid/ready channels of the armed differential drive mixer
// Command channel and motor command channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface admm_req_if;
   logic                                valid;
   logic                                ready;
   logic [admm_pkg::OP_W-1:0]           operation;
   logic signed [admm_pkg::AXIS_W-1:0]  throttle;
   logic signed [admm_pkg::AXIS_W-1:0]  steer;

   modport source (output valid, operation, throttle, steer, input ready);
   modport sink   (input valid, operation, throttle, steer, output ready);
endinterface

interface admm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [admm_pkg::TGT_W-1:0]          target;
   logic [admm_pkg::DIR_W-1:0]          drive_direction;
   logic [admm_pkg::SPEED_W-1:0]        speed;
   logic                                armed_flag;
   logic                                last_of_run;

   modport source (output valid, target, drive_direction, speed, armed_flag,
                   last_of_run, input ready);
   modport sink   (input valid, target, drive_direction, speed, armed_flag,
                   last_of_run, output ready);
endinterface

FILE: sv/admm_mix.sv
// ----------------------------------------------------------------------------
// admm_mix: throttle/steer mixer
// Mixes the two axes into left and right values, clamps them, and derives
// side directions, side speeds and the overall direction.
// ----------------------------------------------------------------------------
module admm_mix (
   input  logic signed [admm_pkg::AXIS_W-1:0] throttle,
   input  logic signed [admm_pkg::AXIS_W-1:0] steer,
   input  logic [admm_pkg::DB_W-1:0]          deadband,
   output admm_pkg::mix_result_type           mix
);

   logic signed [admm_pkg::MIX_W-1:0] th_ext;
   logic signed [admm_pkg::MIX_W-1:0] st_ext;
   logic signed [admm_pkg::MIX_W-1:0] db_ext;
   logic signed [admm_pkg::MIX_W-1:0] left_sum;
   logic signed [admm_pkg::MIX_W-1:0] right_sum;
   logic signed [admm_pkg::MIX_W-1:0] left_clamp;
   logic signed [admm_pkg::MIX_W-1:0] right_clamp;
   logic signed [admm_pkg::MIX_W-1:0] left_abs;
   logic signed [admm_pkg::MIX_W-1:0] right_abs;
   logic [admm_pkg::MAG_W+7:0]        left_prod;
   logic [admm_pkg::MAG_W+7:0]        right_prod;

   assign th_ext    = {throttle[admm_pkg::AXIS_W-1], throttle};
   assign st_ext    = {steer[admm_pkg::AXIS_W-1], steer};
   assign db_ext    = {2'b00, deadband};
   assign left_sum  = th_ext + st_ext;
   assign right_sum = th_ext - st_ext;

   always_comb begin
      if (left_sum > admm_pkg::MIX_LIMIT) begin
         left_clamp = admm_pkg::MIX_LIMIT;
      end else if (left_sum < -admm_pkg::MIX_LIMIT) begin
         left_clamp = -admm_pkg::MIX_LIMIT;
      end else begin
         left_clamp = left_sum;
      end
      if (right_sum > admm_pkg::MIX_LIMIT) begin
         right_clamp = admm_pkg::MIX_LIMIT;
      end else if (right_sum < -admm_pkg::MIX_LIMIT) begin
         right_clamp = -admm_pkg::MIX_LIMIT;
      end else begin
         right_clamp = right_sum;
      end
   end

   assign left_abs   = left_clamp[admm_pkg::MIX_W-1] ? -left_clamp : left_clamp;
   assign right_abs  = right_clamp[admm_pkg::MIX_W-1] ? -right_clamp : right_clamp;
   assign left_prod  = left_abs[admm_pkg::MAG_W-1:0] * admm_pkg::RECIP;
   assign right_prod = right_abs[admm_pkg::MAG_W-1:0] * admm_pkg::RECIP;

   always_comb begin
      if (th_ext > db_ext) begin
         mix.overall = admm_pkg::DIR_FWD;
      end else if (th_ext < -db_ext) begin
         mix.overall = admm_pkg::DIR_REV;
      end else begin
         mix.overall = admm_pkg::DIR_HALT;
      end
      mix.left_rev    = left_clamp[admm_pkg::MIX_W-1];
      mix.right_rev   = right_clamp[admm_pkg::MIX_W-1];
      mix.left_speed  =
         left_prod[admm_pkg::RECIP_SHIFT +: admm_pkg::SPEED_W];
      mix.right_speed =
         right_prod[admm_pkg::RECIP_SHIFT +: admm_pkg::SPEED_W];
   end

endmodule

FILE: sv/armed_differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// armed_differential_drive_mixer: armed differential drive mixer, top level
// Takes drive commands, keeps the armed/mixing state and emits motor commands.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    operation, throttle, steer
//  rsp      out  valid/ready    target, drive_direction, speed, armed_flag,
//                               last_of_run
//  csr      in   csr_we         csr_wdata (deadband)
//
// One command is taken per cycle into the input register while req.ready is high;
// it is executed from there, and its motor commands (0 to 4) load the run register.
// The run register sends one motor command per cycle while rsp.ready is high.
// Reset is synchronous and clears the valid flags and architectural state at once;
// deadband returns to 20.
// rsp.ready low holds the current motor command; a command with results waits
// in the input register until the run register drains, and req.ready drops.
module armed_differential_drive_mixer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [admm_pkg::DB_W-1:0]  csr_wdata,
   admm_req_if.sink                   req,
   admm_rsp_if.source                 rsp
);

   // input register
   logic                                in_valid_ff;
   logic [admm_pkg::OP_W-1:0]           in_op_ff;
   logic signed [admm_pkg::AXIS_W-1:0]  in_th_ff;
   logic signed [admm_pkg::AXIS_W-1:0]  in_st_ff;

   // architectural state
   logic [admm_pkg::DB_W-1:0]     deadband_ff;
   logic                          armed_ff, armed_in;
   admm_pkg::dir_type             overall_ff, overall_in;
   admm_pkg::dir_type             prev_ff, prev_in;
   logic                          left_rev_ff, left_rev_in;
   logic                          right_rev_ff, right_rev_in;
   logic [admm_pkg::SPEED_W-1:0]  left_speed_ff, left_speed_in;
   logic [admm_pkg::SPEED_W-1:0]  right_speed_ff, right_speed_in;
   logic                          pending_ff, pending_in;
   logic                          turning_ff, turning_in;

   // run register
   logic                          run_valid_ff;
   logic [admm_pkg::RUN_W-1:0]    run_idx_ff;
   logic [admm_pkg::RUN_W-1:0]    run_last_ff, run_last_in;
   logic                          run_armed_ff, run_armed_in;
   admm_pkg::entry_type           run_ent_ff [admm_pkg::RUN_MAX];
   admm_pkg::entry_type           run_ent_in [admm_pkg::RUN_MAX];

   admm_pkg::mix_result_type      mix;
   admm_pkg::entry_type           cur;
   logic                          has_run;
   logic                          run_done;
   logic                          run_free;
   logic                          proc_go;
   logic [admm_pkg::RUN_W-1:0]    n_stops;
   logic                          dir_change;
   logic                          turn_change;

   admm_mix u_mix (
      .throttle (in_th_ff),
      .steer    (in_st_ff),
      .deadband (deadband_ff),
      .mix      (mix)
   );

   assign dir_change  = (overall_ff != prev_ff);
   assign turn_change = ((left_rev_ff != right_rev_ff) != turning_ff);
   assign n_stops     = {1'b0, dir_change} + {1'b0, turn_change};

   always_comb begin
      armed_in       = armed_ff;
      overall_in     = overall_ff;
      prev_in        = prev_ff;
      left_rev_in    = left_rev_ff;
      right_rev_in   = right_rev_ff;
      left_speed_in  = left_speed_ff;
      right_speed_in = right_speed_ff;
      pending_in     = pending_ff;
      turning_in     = turning_ff;
      has_run        = 1'b0;
      run_last_in    = '0;
      run_armed_in   = armed_ff;
      for (int i = 0; i < admm_pkg::RUN_MAX; i++) begin
         run_ent_in[i] = '{target: admm_pkg::TGT_STOP, dir: admm_pkg::DIR_HALT,
                           speed: '0};
      end
      case (admm_pkg::op_type'(in_op_ff))
         admm_pkg::OP_MANUAL: begin
            if (armed_ff) begin
               overall_in     = mix.overall;
               left_rev_in    = mix.left_rev;
               right_rev_in   = mix.right_rev;
               left_speed_in  = mix.left_speed;
               right_speed_in = mix.right_speed;
               pending_in     = 1'b1;
            end
         end
         admm_pkg::OP_APPLY: begin
            if (armed_ff && pending_ff) begin
               has_run      = 1'b1;
               run_armed_in = 1'b1;
               run_last_in  = n_stops + 2'd1;
               prev_in      = overall_ff;
               turning_in   = (left_rev_ff != right_rev_ff);
               pending_in   = 1'b0;
               // stops first, then left, then right
               for (int i = 0; i < admm_pkg::RUN_MAX; i++) begin
                  if (admm_pkg::RUN_W'(i) == n_stops) begin
                     run_ent_in[i].target = admm_pkg::TGT_LEFT;
                     run_ent_in[i].dir    = left_rev_ff ? admm_pkg::DIR_REV
                                                        : admm_pkg::DIR_FWD;
                     run_ent_in[i].speed  = left_speed_ff;
                  end else if (admm_pkg::RUN_W'(i) == n_stops + 2'd1) begin
                     run_ent_in[i].target = admm_pkg::TGT_RIGHT;
                     run_ent_in[i].dir    = right_rev_ff ? admm_pkg::DIR_REV
                                                         : admm_pkg::DIR_FWD;
                     run_ent_in[i].speed  = right_speed_ff;
                  end
               end
            end
         end
         admm_pkg::OP_ARM: begin
            armed_in = 1'b1;
         end
         admm_pkg::OP_DISARM: begin
            armed_in       = 1'b0;
            overall_in     = admm_pkg::DIR_HALT;
            left_speed_in  = '0;
            right_speed_in = '0;
            has_run        = 1'b1;
            run_armed_in   = 1'b0;
            run_ent_in[0].target = admm_pkg::TGT_HARD;
         end
         admm_pkg::OP_SOFT: begin
            overall_in     = admm_pkg::DIR_HALT;
            left_speed_in  = '0;
            right_speed_in = '0;
            pending_in     = 1'b1;
         end
         admm_pkg::OP_RESET: begin
            armed_in       = 1'b0;
            left_speed_in  = '0;
            right_speed_in = '0;
            prev_in        = admm_pkg::DIR_HALT;
            turning_in     = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign run_done  = run_valid_ff && rsp.ready && (run_idx_ff == run_last_ff);
   assign run_free  = !run_valid_ff || run_done;
   assign proc_go   = in_valid_ff && (!has_run || run_free);
   assign req.ready = !in_valid_ff || proc_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_op_ff <= req.operation;
         in_th_ff <= req.throttle;
         in_st_ff <= req.steer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= admm_pkg::DEADBAND_RESET;
      end else if (csr_we) begin
         deadband_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         overall_ff     <= admm_pkg::DIR_HALT;
         prev_ff        <= admm_pkg::DIR_HALT;
         left_rev_ff    <= 1'b0;
         right_rev_ff   <= 1'b0;
         left_speed_ff  <= '0;
         right_speed_ff <= '0;
         pending_ff     <= 1'b0;
         turning_ff     <= 1'b0;
      end else if (proc_go) begin
         armed_ff       <= armed_in;
         overall_ff     <= overall_in;
         prev_ff        <= prev_in;
         left_rev_ff    <= left_rev_in;
         right_rev_ff   <= right_rev_in;
         left_speed_ff  <= left_speed_in;
         right_speed_ff <= right_speed_in;
         pending_ff     <= pending_in;
         turning_ff     <= turning_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_idx_ff   <= '0;
      end else if (proc_go && has_run) begin
         run_valid_ff <= 1'b1;
         run_idx_ff   <= '0;
      end else if (run_done) begin
         run_valid_ff <= 1'b0;
      end else if (run_valid_ff && rsp.ready) begin
         // advance to the next motor command of this run
         run_idx_ff <= run_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && has_run) begin
         run_last_ff  <= run_last_in;
         run_armed_ff <= run_armed_in;
         run_ent_ff   <= run_ent_in;
      end
   end

   assign cur                 = run_ent_ff[run_idx_ff];
   assign rsp.valid           = run_valid_ff;
   assign rsp.target          = cur.target;
   assign rsp.drive_direction = cur.dir;
   assign rsp.speed           = cur.speed;
   assign rsp.armed_flag      = run_armed_ff;
   assign rsp.last_of_run     = (run_idx_ff == run_last_ff);

endmodule

FILE: sv/admm_checker.sv
// ----------------------------------------------------------------------------
// admm_checker: port-level checks of the armed differential drive mixer
// Watches the motor command channel and flags malformed transactions.
// ----------------------------------------------------------------------------
module admm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [admm_pkg::TGT_W-1:0]    rsp_target,
   input logic [admm_pkg::DIR_W-1:0]    rsp_drive_direction,
   input logic [admm_pkg::SPEED_W-1:0]  rsp_speed,
   input logic                          rsp_armed_flag,
   input logic                          rsp_last_of_run
);

   // hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target)
         && $stable(rsp_drive_direction) && $stable(rsp_speed)
         && $stable(rsp_armed_flag) && $stable(rsp_last_of_run))
      else $error("motor command changed while stalled");

   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == admm_pkg::TGT_STOP
                    || rsp_target == admm_pkg::TGT_HARD)
      |-> rsp_drive_direction == admm_pkg::DIR_HALT && rsp_speed == '0)
      else $error("stop command carries direction or speed");

   a_hard_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == admm_pkg::TGT_HARD
      |-> !rsp_armed_flag && rsp_last_of_run)
      else $error("hard stop not a lone disarmed transaction");

   // left is always followed by right, which closes the run
   a_left_then_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_target == admm_pkg::TGT_LEFT
      |=> rsp_valid && rsp_target == admm_pkg::TGT_RIGHT && rsp_last_of_run
         && rsp_armed_flag)
      else $error("left motor command not followed by right");

   a_motor_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == admm_pkg::TGT_LEFT
                    || rsp_target == admm_pkg::TGT_RIGHT)
      |-> rsp_speed <= 7'd100 && rsp_drive_direction != admm_pkg::DIR_HALT)
      else $error("motor command out of range");

endmodule

bind armed_differential_drive_mixer admm_checker u_admm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_target          (rsp.target),
   .rsp_drive_direction (rsp.drive_direction),
   .rsp_speed           (rsp.speed),
   .rsp_armed_flag      (rsp.armed_flag),
   .rsp_last_of_run     (rsp.last_of_run)
);
